### rtl/mux_input_change_events_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multiplexed input change-event scanner
// Both macros expect clk and arst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef MUX_INPUT_CHANGE_EVENTS_DEFINES_SVH
`define MUX_INPUT_CHANGE_EVENTS_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MIC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("mic assertion failed");

// Consequent checked in the cycle after the antecedent.
`define MIC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("mic assertion failed");

`endif

### rtl/mic_pkg.sv
// ---------------------------------------------------------------------------
// mic_pkg
// Types, constants and helpers shared by the change-event scanner modules.
// ---------------------------------------------------------------------------
package mic_pkg;

	localparam int CHANNELS    = 16;
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHANNELS-1:0] FULL_MASK = {CHANNELS{1'b1}};
	localparam logic [CHANNELS-1:0] HALF_MASK = {{(CHANNELS-8){1'b0}}, 8'hFF};

	typedef enum logic [1:0] {
		OP_UPDATE    = 2'd0,
		OP_RETRIGGER = 2'd1,
		OP_CLEAR     = 2'd2,
		OP_NONE      = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [CHANNELS-1:0] sampled_levels;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            is_release;
		logic            last;
	} evt_t;

	// One scheduled burst of events. Channels in mask_a go out first, then
	// those in mask_b, which are always presses.
	typedef struct packed {
		logic [CHANNELS-1:0] mask_a;
		logic [CHANNELS-1:0] mask_b;
		logic [CHANNELS-1:0] levels;
		logic                retrig;
	} job_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [CH_W-1:0] lowest_set(input logic [CHANNELS-1:0] m);
		logic [CH_W-1:0] idx;
		idx = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (m[i]) idx = CH_W'(i);
		end
		return idx;
	endfunction

endpackage

### rtl/mux_input_change_events.sv
// ---------------------------------------------------------------------------
// mux_input_change_events
// Turns scanned input level vectors into press and release events.
// ---------------------------------------------------------------------------
// A request carries an opcode and a sampled level vector, bit k for channel k.
// An update emits one event per changed channel in ascending order; a
// retrigger emits a release for every high channel, then a press for every
// low one; a clear zeroes the stored levels and emits nothing. The event
// marked last closes the burst of one request. cfg_we writes half_size
// (eight channels when set, sixteen when clear).
// The front stage classifies a request in the cycle it is accepted and puts
// an event job into a two-entry queue. The back end walks that job at one
// event per cycle while the receiver does not stall, so a retrigger gives 8
// or 16 events; a request with no events never enters the queue. A job goes
// through the queue and the back-end masks before its first event is output.
// req_ready drops only while the queue is full. A stalled receiver holds the
// registered event and the back end waits; the front keeps accepting until
// the queue fills. Reset clears the stored levels, half_size and the queue.
// ---------------------------------------------------------------------------
module mux_input_change_events (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  mic_pkg::req_t req,
	output logic          evt_valid,
	input  logic          evt_ready,
	output mic_pkg::evt_t evt
);
	import mic_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic q_valid;
	job_t q_job;

	mic_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	mic_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	mic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

endmodule

### rtl/mic_front.sv
// ---------------------------------------------------------------------------
// mic_front
// Accepts requests, keeps the stored level vector and turns each request
// into an event job for the back end.
// ---------------------------------------------------------------------------
module mic_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  mic_pkg::req_t req,
	input  logic          q_full,
	output logic          push,
	output mic_pkg::job_t push_job
);
	import mic_pkg::*;

	logic                half_size_q;
	logic [CHANNELS-1:0] stored_q;
	logic [CHANNELS-1:0] amask;
	logic [CHANNELS-1:0] cur;
	logic                accept;

	assign req_ready = !q_full;
	assign accept    = req_valid && req_ready;
	assign amask     = half_size_q ? HALF_MASK : FULL_MASK;
	assign cur       = req.sampled_levels & amask;

	always_comb begin
		push_job = '0;
		unique case (req.opcode)
			OP_UPDATE: begin
				push_job.mask_a = (stored_q ^ cur) & amask;
				push_job.levels = cur;
			end
			OP_RETRIGGER: begin
				push_job.mask_a = cur;
				push_job.mask_b = ~cur & amask;
				push_job.levels = cur;
				push_job.retrig = 1'b1;
			end
			OP_CLEAR: push_job = '0;
			OP_NONE:  push_job = '0;
		endcase
	end

	// Requests that cause no event never reach the queue.
	assign push = accept && ((|push_job.mask_a) || (|push_job.mask_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q <= 1'b0;
			stored_q    <= '0;
		end else begin
			if (cfg_we) half_size_q <= cfg_wdata;
			if (accept) begin
				unique case (req.opcode)
					OP_UPDATE:    stored_q <= cur;
					OP_RETRIGGER: stored_q <= cur;
					OP_CLEAR:     stored_q <= '0;
					OP_NONE:      stored_q <= stored_q;
				endcase
			end
		end
	end

endmodule

### rtl/mic_queue.sv
// ---------------------------------------------------------------------------
// mic_queue
// Short job queue that decouples request intake from event output.
// ---------------------------------------------------------------------------
module mic_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mic_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output mic_pkg::job_t q_job
);
	import mic_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/mic_back.sv
// ---------------------------------------------------------------------------
// mic_back
// Walks the current job one channel per cycle while the event output is not
// stalled, and drives the registered event output.
// ---------------------------------------------------------------------------
module mic_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  mic_pkg::job_t q_job,
	output logic          pop,
	output logic          evt_valid,
	input  logic          evt_ready,
	output mic_pkg::evt_t evt
);
	import mic_pkg::*;

	logic [CHANNELS-1:0] mask_a_q;
	logic [CHANNELS-1:0] mask_b_q;
	logic [CHANNELS-1:0] levels_q;
	logic                retrig_q;
	logic                evt_valid_q;
	evt_t                evt_q;

	logic                work_nz;
	logic                can_emit;
	logic                emit;
	logic                use_a;
	logic [CHANNELS-1:0] sel;
	logic [CH_W-1:0]     ch;
	logic                rel;
	logic [CHANNELS-1:0] a_next;
	logic [CHANNELS-1:0] b_next;
	logic                rem_zero;

	assign work_nz  = (|mask_a_q) || (|mask_b_q);
	assign can_emit = !evt_valid_q || evt_ready;
	assign emit     = can_emit && work_nz;
	assign use_a    = |mask_a_q;
	assign sel      = use_a ? mask_a_q : mask_b_q;
	assign ch       = lowest_set(sel);
	assign rel      = use_a ? (retrig_q || levels_q[ch]) : 1'b0;
	assign a_next   = use_a ? (mask_a_q & (mask_a_q - 1'b1)) : mask_a_q;
	assign b_next   = use_a ? mask_b_q : (mask_b_q & (mask_b_q - 1'b1));
	assign rem_zero = (a_next == '0) && (b_next == '0);

	// The next job loads in the same cycle as the final event of this one.
	assign pop = q_valid && (!work_nz || (emit && rem_zero));

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_a_q    <= '0;
			mask_b_q    <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			if (can_emit) evt_valid_q <= work_nz;
			// A pop during an emit only happens on the final event, when both
			// remaining masks are already empty.
			if (pop) begin
				mask_a_q <= q_job.mask_a;
				mask_b_q <= q_job.mask_b;
			end else if (emit) begin
				mask_a_q <= a_next;
				mask_b_q <= b_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			evt_q.channel    <= ch;
			evt_q.is_release <= rel;
			evt_q.last       <= rem_zero;
		end
		if (pop) begin
			levels_q <= q_job.levels;
			retrig_q <= q_job.retrig;
		end
	end

endmodule

### rtl/mic_checker.sv
// ---------------------------------------------------------------------------
// mic_checker
// Port-level checks on handshake stability, event ordering and burst length, bound to the top.
// ---------------------------------------------------------------------------
`include "mux_input_change_events_defines.svh"

module mic_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input mic_pkg::req_t req,
	input logic          evt_valid,
	input logic          evt_ready,
	input mic_pkg::evt_t evt
);
	import mic_pkg::*;

	logic                prev_open_q;
	logic [CH_W-1:0]     prev_ch_q;
	logic                prev_rel_q;
	logic [CH_W:0]       cnt_q;
	logic                evt_acc;

	assign evt_acc = evt_valid && evt_ready;

	// Tracks the previous event of the burst still in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_open_q <= 1'b0;
			prev_ch_q   <= '0;
			prev_rel_q  <= 1'b0;
			cnt_q       <= '0;
		end else if (evt_acc) begin
			prev_open_q <= !evt.last;
			prev_ch_q   <= evt.channel;
			prev_rel_q  <= evt.is_release;
			cnt_q       <= evt.last ? '0 : cnt_q + 1'b1;
		end
	end

	`MIC_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))
	`MIC_ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready, evt_valid && $stable(evt))
	`MIC_ASSERT_NOW(a_evt_order, evt_valid && prev_open_q, (evt.channel > prev_ch_q) || (prev_rel_q && !evt.is_release))
	`MIC_ASSERT_NOW(a_burst_len, evt_valid, cnt_q < (CH_W + 1)'(CHANNELS))

endmodule

bind mux_input_change_events mic_checker u_mic_checker (.*);
